// File: hdl/b2da_pkg.sv
`timescale 1ns / 1ps

package b2da_pkg;

  localparam int VALUE_W    = 64;
  localparam int BCD_DIGITS = 20;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
  localparam int CHAR_W     = 6;
  localparam int CNT_W      = $clog2(VALUE_W + 1);
  localparam int REM_W      = $clog2(BCD_DIGITS + 1);

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
  localparam logic [DIGIT_W-1:0] DABBLE_MIN = DIGIT_W'(5);
  localparam logic [DIGIT_W-1:0] DABBLE_ADD = DIGIT_W'(3);

  typedef struct packed {
    logic start;
    logic shift_digit;
  } dabble_cmd_t;

  typedef struct packed {
    logic busy;
  } dabble_stat_t;

endpackage

// File: hdl/binary_to_decimal_ascii.sv
`timescale 1ns / 1ps
// sequence: after the input transaction the bit-serial double dabble loop shifts and corrects
// over the 64 input bits, hands over, drops z = 0 to 19 leading zeros one per cycle,
// then loads the output register; then one digit per cycle while out_ready holds
// a new number is taken only in IDLE, once the last digit of the previous one is loaded,
// so the double dabble loop and the 20-digit skip and emit pass do not overlap between items
// reset: synchronous, clears the state machine and the output valid; data regs keep value
module binary_to_decimal_ascii (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [b2da_pkg::VALUE_W-1:0]       value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [b2da_pkg::CHAR_W-1:0]        digit_char,
  output logic                               last
);
  import b2da_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    CONV,
    SKIP,
    EMIT
  } state_t;

  state_t             state;
  logic [REM_W-1:0]   remaining;   // digits still held in the bcd register
  dabble_cmd_t        cmd;
  dabble_stat_t       stat;
  logic [DIGIT_W-1:0] msd;
  logic               skip_zero;
  logic               load;

  // double dabble core: holds the bcd digits and shifts them out msd first
  b2da_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .value (value),
    .stat  (stat),
    .msd   (msd)
  );

  assign in_ready = (state == IDLE);

  // a leading zero is dropped unless it is the only digit left
  assign skip_zero = (msd == '0) && (remaining > REM_W'(1));

  // output register is free when empty or being taken this cycle
  assign load = !out_valid || out_ready;

  always_comb begin
    cmd.start       = in_valid && in_ready;
    cmd.shift_digit = ((state == SKIP) && skip_zero) || ((state == EMIT) && load);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      // a taken digit frees the output register; emit refills it in the same cycle
      if (out_valid && out_ready && (state != EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state <= CONV;
          end
        end
        CONV: begin
          // core raises busy at the accepting edge, so this waits for the end
          if (!stat.busy) begin
            remaining <= REM_W'(BCD_DIGITS);
            state     <= SKIP;
          end
        end
        SKIP: begin
          if (skip_zero) begin
            remaining <= remaining - REM_W'(1);
          end else begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (load) begin
            out_valid  <= 1'b1;
            digit_char <= CHAR_W'(msd) + ASCII_ZERO;
            last       <= (remaining == REM_W'(1));
            remaining  <= remaining - REM_W'(1);
            if (remaining == REM_W'(1)) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/b2da_dabble.sv
`timescale 1ns / 1ps

module b2da_dabble (
  input  logic                                clk,
  input  logic                                rst,
  input  b2da_pkg::dabble_cmd_t               cmd,
  input  logic [b2da_pkg::VALUE_W-1:0]        value,
  output b2da_pkg::dabble_stat_t              stat,
  output logic [b2da_pkg::DIGIT_W-1:0]        msd
);
  import b2da_pkg::*;

  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_adj;
  logic [CNT_W-1:0]   cnt;
  logic               busy;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= DABBLE_MIN) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(VALUE_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      bin <= value;
      bcd <= '0;
    end else if (busy) begin
      bin <= {bin[VALUE_W-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
    end else if (cmd.shift_digit) begin
      bcd <= {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  assign stat.busy = busy;
  assign msd       = bcd[BCD_W-1 -: DIGIT_W];

endmodule

// File: tb/binary_to_decimal_ascii_tb.sv
`timescale 1ns / 1ps

module binary_to_decimal_ascii_tb;

  import b2da_pkg::*;

  localparam int N_DIRECTED   = 23;
  localparam int N_RANDOM     = 200;
  localparam int N_ITEMS      = N_DIRECTED + N_RANDOM;
  // worst item: long input gap, a full conversion in the block, 20 stalled digits
  localparam int CYCLE_LIMIT  = 400000;
  // quiet time after the last digit: one full conversion plus the longest number
  localparam int DRAIN_CYCLES = 150;
  localparam int MAX_REPORTS  = 10;

  // one expected output transaction
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [VALUE_W-1:0] value     = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CHAR_W-1:0]  digit_char;
  logic               last;

  // digits still owed by the block, oldest first
  digit_t expected_digits[$];

  int    send_gap_pct   = 27;
  int    recv_stall_pct = 55;
  int    mismatches     = 0;
  int    digits_checked = 0;
  int    numbers_sent   = 0;
  bit [BCD_DIGITS:0] lengths_seen = '0;
  longint cycle_count   = 0;

  // directed numbers: an empty string means the expected digits come from the predictor,
  // otherwise the decimal text is the expected output
  logic [VALUE_W-1:0] dir_value [N_DIRECTED] = '{
    64'd0,                           // zero gives a lone '0'
    64'd1,
    64'd9,
    64'd10,
    64'd99,
    64'd100,
    64'd99999,                       // five-digit group boundary
    64'd100000,
    64'd1000000,
    64'd9999999999,                  // ten-digit group boundary
    64'd10000000000,
    64'd999999999999999,             // fifteen-digit group boundary
    64'd1000000000000000,
    64'd9999999999999999999,         // largest 19-digit number
    64'd10000000000000000000,        // largest power of ten
    64'd9223372036854775807,
    64'd9223372036854775808,         // msb alone
    64'h5555_5555_5555_5555,
    64'hAAAA_AAAA_AAAA_AAAA,
    64'h0000_0000_FFFF_FFFF,
    64'hFFFF_FFFF_0000_0000,
    64'd12345678901234567890,        // every digit value twice
    64'hFFFF_FFFF_FFFF_FFFF          // largest value, 20 digits
  };

  string dir_text [N_DIRECTED] = '{
    "0", "1", "9", "10", "", "", "", "", "", "", "", "", "", "", "10000000000000000000",
    "", "", "", "", "", "", "12345678901234567890", "18446744073709551615"
  };

  binary_to_decimal_ascii u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last       (last)
  );

  always #6 clk = ~clk;

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digits still pending", cycle_count,
               expected_digits.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic void queue_digit(input logic [CHAR_W-1:0] ch, input logic is_last);
    digit_t d;
    d.ch   = ch;
    d.last = is_last;
    expected_digits.push_back(d);
  endfunction

  // decimal digits of a number, most significant first, leading zeros dropped
  function automatic int predict_digits(input logic [VALUE_W-1:0] number);
    logic [DIGIT_W-1:0] rev [BCD_DIGITS];
    logic [VALUE_W-1:0] rest;
    int n;
    rest = number;
    n    = 0;
    // peel digits from the low end; zero still yields one digit
    do begin
      rev[n] = DIGIT_W'(rest % 64'd10);
      rest   = rest / 64'd10;
      n++;
    end while (rest != 0 && n < BCD_DIGITS);
    for (int k = n - 1; k >= 0; k--) begin
      queue_digit(ASCII_ZERO + CHAR_W'(rev[k]), k == 0);
    end
    return n;
  endfunction

  // random numbers spread over all digit counts
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] p10;
    int k;
    v = {$urandom, $urandom};
    case ($urandom_range(3))
      0: begin
        // full 64-bit pattern
      end
      1: begin
        // shorter numbers by dropping high bits
        v = v >> $urandom_range(VALUE_W - 1);
      end
      2: begin
        // just around a power of ten, where the digit count changes
        p10 = 64'd1;
        k   = $urandom_range(BCD_DIGITS - 1);
        repeat (k) p10 = p10 * 64'd10;
        v = p10 + VALUE_W'($urandom_range(4)) - 64'd2;
      end
      default: begin
        v = VALUE_W'($urandom_range(99999));
      end
    endcase
    return v;
  endfunction

  // one input transaction; expected digits are queued when it is accepted
  task automatic send_number(input logic [VALUE_W-1:0] v, input string text);
    int n;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    if (text.len() == 0) begin
      n = predict_digits(v);
    end else begin
      n = text.len();
      for (int i = 0; i < n; i++) queue_digit(CHAR_W'(text[i]), i == n - 1);
    end
    lengths_seen[n] = 1'b1;
    numbers_sent++;
  endtask

  // output side: check each accepted digit, then pick the next ready level
  always @(posedge clk) begin
    digit_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        digits_checked++;
        if (expected_digits.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected digit: char %0d last %0b with no number pending",
                     digit_char, last);
        end else begin
          want = expected_digits.pop_front();
          if (digit_char !== want.ch || last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("digit %0d mismatch: expected char %0d last %0b, got char %0d last %0b",
                       digits_checked, want.ch, want.last, digit_char, last);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase 1: dense input, slow output; phase 2: the reverse; phase 3: full speed
    for (int i = 0; i < N_ITEMS; i++) begin
      if (i == N_ITEMS / 3) begin
        send_gap_pct   = 55;
        recv_stall_pct = 27;
      end else if (i == 2 * N_ITEMS / 3) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      if (i < N_DIRECTED) send_number(dir_value[i], dir_text[i]);
      else send_number(random_value(), "");
    end
    in_valid <= 1'b0;

    while (expected_digits.size() != 0) @(posedge clk);
    // any stray digit after the last expected one shows up here
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d numbers into %0d digits, %0d of 20 digit counts exercised",
             numbers_sent, digits_checked, $countones(lengths_seen));
    $display("%0d mismatches over %0d cycles", mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: binary_to_decimal_ascii.f
hdl/b2da_pkg.sv
hdl/b2da_dabble.sv
hdl/binary_to_decimal_ascii.sv
tb/binary_to_decimal_ascii_tb.sv
